### rtl/core/rcat_pkg.sv
// Shared types and constants for the raster cache admission table.
// Request/result structs, status codes, register indexes and the
// controller/datapath command and status groups. No dependencies.
package rcat_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = 6;
  localparam int SLOT_EXT_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam int THR_W         = 4;
  localparam int LIM_W         = 20;
  localparam int CFG_DATA_W    = 20;
  localparam int CFG_IDX_W     = 1;
  localparam int REMOVED_W     = 7;

  localparam logic [THR_W-1:0] THR_RESET = 4'd3;
  localparam logic [LIM_W-1:0] LIM_RESET = 20'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_COUNT_LIMIT   = 1'b1;

  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_RESET    = 3'd1;
  localparam logic [2:0] ST_COUNTING = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_RASTER   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_SWEEP    = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [31:0] picture_id;
    logic [15:0] size_width;
    logic [15:0] size_height;
    logic [19:0] op_count;
    logic        has_text;
  } in_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [SLOT_W-1:0]    slot;
    logic                 image_ready;
    logic [REMOVED_W-1:0] removed_count;
  } out_rsp_t;

  // Width, height and access count of one entry, held in the entry memory.
  typedef struct packed {
    logic [15:0]      width;
    logic [15:0]      height;
    logic [THR_W-1:0] count;
  } entry_rec_t;

  typedef struct packed {
    logic capture;     // latch a new request
    logic lookup;      // key compare and entry read
    logic sweep_step;  // visit one entry of the sweep
    logic finish;      // apply update, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;        // latched request is a sweep
    logic sweep_last;  // sweep is on the last entry
    logic out_free;    // result register can take a result
  } ctrl_sts_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [SLOT_EXT_W-1:0] ext;
    ext = SLOT_EXT_W'(idx);
    return ext[SLOT_W-1:0];
  endfunction

endpackage

### rtl/core/rcat_ctrl.sv
// Sequencing controller for the raster cache admission table.
// Depends on rcat_pkg for the command and status structs.
module rcat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcat_pkg::ctrl_sts_t sts,
  output rcat_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = sts.mode ? S_SWEEP : S_UPDATE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      S_UPDATE, S_DONE: begin
        // finish once the result register frees up; take the next request too
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_LOOKUP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/rcat_dp.sv
// Datapath for the raster cache admission table: key CAM, flag vectors,
// entry memory, config registers and result register. Depends on rcat_pkg.
module rcat_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rcat_pkg::in_req_t                     in_req,
  input  logic                                  cfg_we,
  input  logic [rcat_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [rcat_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  rcat_pkg::ctrl_cmd_t                   cmd,
  output rcat_pkg::ctrl_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rcat_pkg::out_rsp_t                    out_rsp
);

  localparam int N = rcat_pkg::TABLE_ENTRIES;
  localparam int W = rcat_pkg::IDX_W;

  // Config registers
  logic [rcat_pkg::THR_W-1:0] thr_r;
  logic [rcat_pkg::LIM_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rcat_pkg::THR_RESET;
      lim_r <= rcat_pkg::LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rcat_pkg::CFG_ACCESS_THRESHOLD: thr_r <= cfg_wdata[rcat_pkg::THR_W-1:0];
        rcat_pkg::CFG_OP_COUNT_LIMIT:   lim_r <= cfg_wdata[rcat_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched request
  rcat_pkg::in_req_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_req;
  end

  // Table state
  logic [31:0]  key_r [N];
  logic [N-1:0] valid_r, valid_nxt;
  logic [N-1:0] used_r, used_nxt;
  logic [N-1:0] img_r, img_nxt;
  rcat_pkg::entry_rec_t mem [N];
  rcat_pkg::entry_rec_t rd_r;

  // Key compare and priority encode, lowest slot wins
  logic         hit_c, free_c;
  logic [W-1:0] hit_idx_c, free_idx_c;

  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req_r.picture_id) begin
        hit_c     = 1'b1;
        hit_idx_c = W'(i);
      end
      if (!valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = W'(i);
      end
    end
  end

  logic         hit_r, free_r;
  logic [W-1:0] hit_idx_r, free_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      free_r     <= free_c;
      hit_idx_r  <= hit_idx_c;
      free_idx_r <= free_idx_c;
      rd_r       <= mem[hit_idx_c];
    end
  end

  // Sweep index and removed counter
  logic [W-1:0]                   sweep_idx_r;
  logic [rcat_pkg::REMOVED_W-1:0] removed_r;
  logic                           drop_c;

  assign drop_c = valid_r[sweep_idx_r] && !used_r[sweep_idx_r];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sweep_idx_r <= '0;
      removed_r   <= '0;
    end else if (cmd.sweep_step) begin
      sweep_idx_r <= sweep_idx_r + W'(1);
      if (drop_c && removed_r != {rcat_pkg::REMOVED_W{1'b1}}) begin
        removed_r <= removed_r + rcat_pkg::REMOVED_W'(1);
      end
    end
  end

  // Access decision
  logic                       empty_c, size_same_c, reach_c, worth_c;
  logic [rcat_pkg::THR_W:0]   cnt_c;
  rcat_pkg::out_rsp_t         rsp_c;
  logic                       wr_en_c, key_wr_c;
  logic [W-1:0]               wr_idx_c;
  rcat_pkg::entry_rec_t       wr_rec_c;

  assign empty_c     = (req_r.size_width == 16'd0) || (req_r.size_height == 16'd0);
  assign size_same_c = (rd_r.width == req_r.size_width) && (rd_r.height == req_r.size_height);
  assign cnt_c       = {1'b0, rd_r.count} + (rcat_pkg::THR_W + 1)'(1);
  assign reach_c     = cnt_c >= {1'b0, thr_r};
  assign worth_c     = (req_r.op_count > lim_r) || req_r.has_text;

  always_comb begin
    rsp_c     = '0;
    wr_en_c   = 1'b0;
    key_wr_c  = 1'b0;
    wr_idx_c  = hit_idx_r;
    wr_rec_c  = '{width: req_r.size_width, height: req_r.size_height,
                  count: rcat_pkg::THR_W'(1)};
    valid_nxt = valid_r;
    used_nxt  = used_r;
    img_nxt   = img_r;
    if (req_r.mode) begin
      rsp_c.status        = rcat_pkg::ST_SWEEP;
      rsp_c.removed_count = removed_r;
    end else if (empty_c) begin
      rsp_c.status = rcat_pkg::ST_EMPTY;
    end else if (!hit_r) begin
      if (!free_r) begin
        rsp_c.status = rcat_pkg::ST_FULL;
      end else begin
        wr_en_c              = 1'b1;
        key_wr_c             = 1'b1;
        wr_idx_c             = free_idx_r;
        valid_nxt[free_idx_r] = 1'b1;
        used_nxt[free_idx_r]  = 1'b1;
        img_nxt[free_idx_r]   = 1'b0;
        rsp_c.status         = rcat_pkg::ST_RESET;
        rsp_c.slot           = rcat_pkg::slot_of(free_idx_r);
      end
    end else begin
      used_nxt[hit_idx_r] = 1'b1;
      rsp_c.slot          = rcat_pkg::slot_of(hit_idx_r);
      wr_en_c             = 1'b1;
      if (!size_same_c) begin
        img_nxt[hit_idx_r] = 1'b0;
        rsp_c.status       = rcat_pkg::ST_RESET;
      end else begin
        wr_rec_c.count = reach_c ? thr_r : cnt_c[rcat_pkg::THR_W-1:0];
        if (img_r[hit_idx_r]) begin
          rsp_c.status      = rcat_pkg::ST_HIT;
          rsp_c.image_ready = 1'b1;
        end else if (reach_c && worth_c) begin
          img_nxt[hit_idx_r] = 1'b1;
          rsp_c.status       = rcat_pkg::ST_RASTER;
          rsp_c.image_ready  = 1'b1;
        end else begin
          rsp_c.status = rcat_pkg::ST_COUNTING;
        end
      end
    end
  end

  // Flag vectors: cleared by reset, edited by update and sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      img_r   <= '0;
    end else if (cmd.finish) begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      img_r   <= img_nxt;
    end else if (cmd.sweep_step) begin
      used_r[sweep_idx_r] <= 1'b0;
      if (drop_c) begin
        valid_r[sweep_idx_r] <= 1'b0;
        img_r[sweep_idx_r]   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && key_wr_c) key_r[wr_idx_c] <= req_r.picture_id;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en_c) mem[wr_idx_c] <= wr_rec_c;
  end

  // Result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_rsp <= rsp_c;
  end

  assign out_valid      = out_valid_r;
  assign sts.mode       = req_r.mode;
  assign sts.sweep_last = sweep_idx_r == W'(N - 1);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

### rtl/core/raster_cache_admission_table_top.sv
// Raster cache admission table top: rcat_ctrl and rcat_dp, types from rcat_pkg.
// An access is accepted, looked up (key compare and entry read), then finished, which
// loads the result register; a new request is taken only while idle or in the finish cycle.
// A sweep is looked up, then visits one entry per cycle, then finishes.
// A held result does not block the next request until its finish cycle.
// Synchronous active-low reset clears all flags and sets threshold 3, op limit 10.
module raster_cache_admission_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rcat_pkg::in_req_t                in_req,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output rcat_pkg::out_rsp_t               out_rsp,
  // config write port
  input  logic                             cfg_we,
  input  logic [rcat_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rcat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rcat_pkg::ctrl_cmd_t cmd;
  rcat_pkg::ctrl_sts_t sts;

  // Sequence: accept, lookup, then update or walk the table for a sweep
  rcat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table, decide the status, drive the result register
  rcat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

### sim/tb_raster_cache_admission_table_top.sv
`timescale 1ns / 100ps
// Testbench for raster_cache_admission_table_top: random and directed requests,
// a cycle-free predictor of the admission table and an in-order result check.
// Depends on rcat_pkg and the RTL top level only.
module tb_raster_cache_admission_table_top;

  localparam int NUM_ENTRIES  = rcat_pkg::TABLE_ENTRIES;
  localparam int POOL_MAX     = 96;
  // A sweep visits every entry once, so idling must outlast a whole sweep.
  localparam int DRAIN_CYCLES = rcat_pkg::TABLE_ENTRIES + 16;
  localparam int HOLD_CYCLES  = 300;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  rcat_pkg::in_req_t               in_req    = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rcat_pkg::out_rsp_t              out_rsp;
  logic                            cfg_we    = 1'b0;
  logic [rcat_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [rcat_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  raster_cache_admission_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted copy of the block: registers and the entry table.
  logic [rcat_pkg::THR_W-1:0] thr_reg;
  logic [rcat_pkg::LIM_W-1:0] lim_reg;
  bit                         tbl_valid [NUM_ENTRIES];
  bit                         tbl_used  [NUM_ENTRIES];
  bit                         tbl_image [NUM_ENTRIES];
  logic [31:0]                tbl_key   [NUM_ENTRIES];
  logic [15:0]                tbl_w     [NUM_ENTRIES];
  logic [15:0]                tbl_h     [NUM_ENTRIES];
  logic [rcat_pkg::THR_W-1:0] tbl_count [NUM_ENTRIES];

  // Admission decisions still owed by the block, oldest first.
  rcat_pkg::out_rsp_t pending_results[$];

  int err_count   = 0;
  int burst_left  = 1;
  bit hold_toggle = 1'b0;

  // Picture pool used by the random traffic: id and current size per picture.
  logic [31:0] pool_id [POOL_MAX];
  logic [15:0] pool_w  [POOL_MAX];
  logic [15:0] pool_h  [POOL_MAX];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous run limit: far above the slowest legal run of this stimulus.
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Advance the predicted table by one request and return its decision.
  function automatic rcat_pkg::out_rsp_t predict_admission(input rcat_pkg::in_req_t r);
    rcat_pkg::out_rsp_t       rsp;
    int                       found;
    int                       free_idx;
    int                       removed;
    logic [rcat_pkg::THR_W:0] cnt;
    rsp      = '0;
    found    = -1;
    free_idx = -1;
    removed  = 0;
    if (r.mode) begin
      // End of frame: drop everything not touched since the last sweep.
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (tbl_valid[i] && !tbl_used[i]) begin
          tbl_valid[i] = 1'b0;
          tbl_image[i] = 1'b0;
          if (removed < 127) removed++;
        end
        tbl_used[i] = 1'b0;
      end
      rsp.status        = rcat_pkg::ST_SWEEP;
      rsp.removed_count = rcat_pkg::REMOVED_W'(removed);
      return rsp;
    end
    if (r.size_width == 16'd0 || r.size_height == 16'd0) begin
      rsp.status = rcat_pkg::ST_EMPTY;
      return rsp;
    end
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (found < 0 && tbl_key[i] == r.picture_id) found = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (found < 0) begin
      if (free_idx < 0) begin
        rsp.status = rcat_pkg::ST_FULL;
        return rsp;
      end
      tbl_valid[free_idx] = 1'b1;
      tbl_key[free_idx]   = r.picture_id;
      tbl_w[free_idx]     = r.size_width;
      tbl_h[free_idx]     = r.size_height;
      tbl_count[free_idx] = rcat_pkg::THR_W'(1);
      tbl_used[free_idx]  = 1'b1;
      tbl_image[free_idx] = 1'b0;
      rsp.status = rcat_pkg::ST_RESET;
      rsp.slot   = rcat_pkg::SLOT_W'(free_idx);
      return rsp;
    end
    tbl_used[found] = 1'b1;
    rsp.slot = rcat_pkg::SLOT_W'(found);
    if (tbl_w[found] != r.size_width || tbl_h[found] != r.size_height) begin
      tbl_w[found]     = r.size_width;
      tbl_h[found]     = r.size_height;
      tbl_count[found] = rcat_pkg::THR_W'(1);
      tbl_image[found] = 1'b0;
      rsp.status = rcat_pkg::ST_RESET;
      return rsp;
    end
    cnt = {1'b0, tbl_count[found]} + (rcat_pkg::THR_W + 1)'(1);
    if (cnt >= {1'b0, thr_reg}) begin
      tbl_count[found] = thr_reg;
      if (!tbl_image[found] && (r.op_count > lim_reg || r.has_text)) begin
        tbl_image[found]  = 1'b1;
        rsp.status      = rcat_pkg::ST_RASTER;
        rsp.image_ready = 1'b1;
        return rsp;
      end
    end else begin
      tbl_count[found] = cnt[rcat_pkg::THR_W-1:0];
    end
    if (tbl_image[found]) begin
      rsp.status      = rcat_pkg::ST_HIT;
      rsp.image_ready = 1'b1;
    end else begin
      rsp.status = rcat_pkg::ST_COUNTING;
    end
    return rsp;
  endfunction

  function automatic rcat_pkg::in_req_t mk_access(input logic [31:0] id,
                                                  input logic [15:0] w, h,
                                                  input logic [19:0] ops,
                                                  input logic text);
    rcat_pkg::in_req_t r;
    r.mode        = 1'b0;
    r.picture_id  = id;
    r.size_width  = w;
    r.size_height = h;
    r.op_count    = ops;
    r.has_text    = text;
    return r;
  endfunction

  function automatic rcat_pkg::in_req_t rand_req();
    rcat_pkg::in_req_t r;
    r.mode        = 1'($urandom);
    r.picture_id  = $urandom;
    r.size_width  = 16'($urandom);
    r.size_height = 16'($urandom);
    r.op_count    = 20'($urandom);
    r.has_text    = 1'($urandom);
    return r;
  endfunction

  // Operation counts cluster around the current limit so that both sides
  // of the "worth rasterizing" compare get hit.
  function automatic logic [19:0] pick_ops();
    case ($urandom_range(0, 5))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      2, 3:    return lim_reg + 20'($urandom_range(0, 2)) - 20'd1;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // Offer one request, hold it until accepted, then record its prediction.
  // Bursts end with a random gap; the next call raises valid again.
  task automatic send_request(input rcat_pkg::in_req_t r);
    rcat_pkg::out_rsp_t owed;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    owed = predict_admission(r);
    pending_results = {pending_results, owed};
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
  endtask

  // Drop valid, let every owed result drain, then give a sweep time to end.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; only the low bits of the threshold count.
  task automatic set_config(input logic [rcat_pkg::CFG_DATA_W-1:0] thr_data,
                            input logic [rcat_pkg::LIM_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= rcat_pkg::CFG_ACCESS_THRESHOLD;
    cfg_wdata <= thr_data;
    @(posedge clk);
    thr_reg = thr_data[rcat_pkg::THR_W-1:0];
    cfg_idx   <= rcat_pkg::CFG_OP_COUNT_LIMIT;
    cfg_wdata <= rcat_pkg::CFG_DATA_W'(lim);
    @(posedge clk);
    lim_reg = lim;
    cfg_we <= 1'b0;
  endtask

  // Walk one picture through reset, counting, raster and hit, plus empty sizes,
  // sweeps, a zero threshold and a lowered threshold.
  task automatic test_directed();
    rcat_pkg::in_req_t r;
    logic [31:0]       id_a;
    logic [31:0]       id_d;
    id_a = $urandom;
    id_d = $urandom;
    // Empty width, empty height.
    send_request(mk_access(id_a, 16'd0, 16'd7, 20'hFFFFF, 1'b1));
    send_request(mk_access($urandom, 16'd9, 16'd0, 20'd0, 1'b0));
    // New entry, count up, cross the threshold with ops at then above the limit.
    send_request(mk_access(id_a, 16'd100, 16'd50, 20'd0, 1'b0));
    send_request(mk_access(id_a, 16'd100, 16'd50, 20'd0, 1'b0));
    send_request(mk_access(id_a, 16'd100, 16'd50, 20'd10, 1'b0));
    send_request(mk_access(id_a, 16'd100, 16'd50, 20'd11, 1'b0));
    send_request(mk_access(id_a, 16'd100, 16'd50, 20'd0, 1'b0));
    // Size change drops the image.
    send_request(mk_access(id_a, 16'd101, 16'd50, 20'd0, 1'b0));
    // All-ones picture, with text and an op count above the limit.
    send_request(mk_access(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1));
    send_request(mk_access(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1));
    send_request(mk_access(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1));
    // Sweep with every other field set, then one that removes both pictures.
    r = '1;
    send_request(r);
    r = '0;
    r.mode = 1'b1;
    send_request(r);
    // Zero threshold: every matching access is considered.
    wait_idle();
    set_config(20'hFFFF0, 20'd0);
    send_request(mk_access(32'd0, 16'd1, 16'd1, 20'd0, 1'b0));
    send_request(mk_access(32'd0, 16'd1, 16'd1, 20'd0, 1'b0));
    send_request(mk_access(32'd0, 16'd1, 16'd1, 20'd1, 1'b0));
    // Highest threshold and limit: count up, then lower the threshold to clamp.
    wait_idle();
    set_config(20'd15, 20'hFFFFF);
    repeat (6) send_request(mk_access(id_d, 16'd640, 16'd480, 20'hFFFFF, 1'b0));
    wait_idle();
    set_config(20'd2, 20'd10);
    send_request(mk_access(id_d, 16'd640, 16'd480, 20'd0, 1'b1));
    wait_idle();
    set_config(20'(rcat_pkg::THR_RESET), rcat_pkg::LIM_RESET);
  endtask

  // Random frames over a pool of pictures: mostly repeat accesses at a
  // stable size, some size changes, empty sizes and end-of-frame sweeps.
  task automatic test_random_traffic(input int items, input int pool_n,
                                     input int sweep_one_in);
    rcat_pkg::in_req_t r;
    int                k;
    int                roll;
    for (int i = 0; i < pool_n; i++) begin
      pool_id[i] = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      pool_w[i]  = 16'($urandom_range(1, 65535));
      pool_h[i]  = 16'($urandom_range(1, 65535));
    end
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(1, sweep_one_in) == 1) begin
        r = rand_req();
        r.mode = 1'b1;
      end else if (roll < 6) begin
        r = rand_req();
        r.mode = 1'b0;
        case ($urandom_range(0, 2))
          0:       r.size_width = 16'd0;
          1:       r.size_height = 16'd0;
          default: begin
            r.size_width  = 16'd0;
            r.size_height = 16'd0;
          end
        endcase
      end else begin
        k = $urandom_range(0, pool_n - 1);
        if (roll < 14) begin
          pool_w[k] = 16'($urandom_range(1, 65535));
          pool_h[k] = ($urandom_range(0, 1) == 0) ? pool_h[k]
                                                  : 16'($urandom_range(1, 65535));
        end
        r = mk_access(pool_id[k], pool_w[k], pool_h[k], pick_ops(),
                      1'($urandom_range(0, 3) == 0));
      end
      send_request(r);
    end
  endtask

  // Empty the table, fill every slot, overflow it, then sweep it clean.
  task automatic test_table_full();
    logic [31:0]       base;
    rcat_pkg::in_req_t r;
    base = $urandom;
    r = rand_req();
    r.mode = 1'b1;
    send_request(r);
    send_request(r);
    for (int i = 0; i < NUM_ENTRIES + 2; i++)
      send_request(mk_access(base + 32'(i), 16'(i + 1), 16'(i + 1), pick_ops(), 1'b0));
    send_request(mk_access(base + 32'd5, 16'd6, 16'd6, 20'd0, 1'b0));
    send_request(mk_access(base + 32'd5, 16'd6, 16'd6, 20'd0, 1'b1));
    send_request(r);
    send_request(mk_access(~base, 16'd3, 16'd3, 20'd0, 1'b0));
    send_request(r);
  endtask

  // Hold off the result side for a long stretch while requests keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    int k;
    hold_toggle = ~hold_toggle;
    burst_left  = 1000;
    for (int n = 0; n < 40; n++) begin
      k = $urandom_range(0, 7);
      send_request(mk_access(pool_id[k], pool_w[k], pool_h[k], pick_ops(),
                             1'($urandom)));
    end
    burst_left = 1;
  endtask

  // Result side: stall in segments of random density, or hold off entirely
  // while hold_cnt counts down, once the backpressure test starts.
  int stall_pct = 0;
  int seg_left  = 0;
  int hold_cnt  = 0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_cnt  = HOLD_CYCLES;
    end
    if (seg_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      seg_left = $urandom_range(5, 60);
    end
    seg_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare every accepted result against the oldest owed decision.
  always @(posedge clk) begin : result_check
    rcat_pkg::out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_rsp.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status != want.status)
          report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
        if (out_rsp.slot != want.slot)
          report_mismatch("slot", 32'(out_rsp.slot), 32'(want.slot));
        if (out_rsp.image_ready != want.image_ready)
          report_mismatch("image_ready", 32'(out_rsp.image_ready),
                          32'(want.image_ready));
        if (out_rsp.removed_count != want.removed_count)
          report_mismatch("removed_count", 32'(out_rsp.removed_count),
                          32'(want.removed_count));
      end
    end
  end

  initial begin
    // Reset state of the predicted table.
    thr_reg = rcat_pkg::THR_RESET;
    lim_reg = rcat_pkg::LIM_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_used[i]  = 1'b0;
      tbl_image[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_w[i]     = '0;
      tbl_h[i]     = '0;
      tbl_count[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(200, 24, 30);

    wait_idle();
    set_config({16'($urandom), 4'd1}, 20'd0);
    test_random_traffic(120, 16, 25);

    wait_idle();
    set_config(20'd15, 20'hFFFFF);
    test_random_traffic(120, 12, 60);

    wait_idle();
    set_config({16'($urandom), 4'd0}, 20'($urandom_range(0, 40)));
    test_random_traffic(100, 20, 30);

    wait_idle();
    test_table_full();

    // Large pool, rare sweeps: the table runs full now and then.
    wait_idle();
    set_config(20'($urandom_range(1, 15)), 20'($urandom_range(0, 30)));
    test_random_traffic(150, 96, 80);
    test_backpressure();

    wait_idle();
    set_config(20'd7, 20'($urandom));
    test_random_traffic(100, 40, 40);

    wait_idle();
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
